[rtl/gtg_pkg.sv]
// ----------------------------------------------------------------------------
// gtg_pkg
// Shared types, constants and the bearing threshold table for the
// go-to-goal steering unit.
// ----------------------------------------------------------------------------
package gtg_pkg;

  // Number of half-degree bearing thresholds (0.5 .. 44.5 degrees).
  localparam int NTHR  = 45;
  localparam int OCT_W = 6;

  localparam logic [63:0] PI4_Q64 = 64'hC90FDAA22168C235;
  localparam logic [63:0] Q63_ONE = 64'h8000000000000000;

  // Result word is fixed by the field widths: 38 bits, padded to 40.
  localparam int OUT_W = 40;

  localparam logic [7:0]  RST_BASE_PWM   = 8'd30;
  localparam logic [15:0] RST_DIST_TOL   = 16'd5;
  localparam logic [7:0]  RST_ANGLE_TOL  = 8'd10;
  localparam logic [7:0]  RST_TRIM_TOL   = 8'd1;
  localparam logic [7:0]  RST_CEILING    = 8'd38;
  localparam logic [7:0]  RST_HOLDOFF    = 8'd50;
  localparam logic [7:0]  PWM_MAX        = 8'd255;

  localparam logic [6:0]  DEG_90  = 7'd90;
  localparam logic [7:0]  DEG_180 = 8'd180;
  localparam logic signed [10:0] WRAP_HI   = 11'sd180;
  localparam logic signed [10:0] WRAP_LO   = -11'sd180;
  localparam logic signed [10:0] WRAP_SPAN = 11'sd360;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_FWD  = 2'd1,
    MOTOR_REV  = 2'd2
  } motor_e;

  typedef enum logic [2:0] {
    CFG_LEFT_BASE  = 3'd0,
    CFG_RIGHT_BASE = 3'd1,
    CFG_DIST_TOL   = 3'd2,
    CFG_ANGLE_TOL  = 3'd3,
    CFG_TRIM_TOL   = 3'd4,
    CFG_CEILING    = 3'd5,
    CFG_HOLDOFF    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  left_base;
    logic [7:0]  right_base;
    logic [15:0] dist_tol;
    logic [7:0]  angle_tol;
    logic [7:0]  trim_tol;
    logic [7:0]  ceiling;
    logic [7:0]  holdoff;
  } cfg_t;

  typedef struct packed {
    logic              far;
    logic signed [8:0] err;
  } steer_req_t;

  typedef struct packed {
    motor_e     left_motor;
    motor_e     right_motor;
    logic [7:0] left_pwm;
    logic [7:0] right_pwm;
  } steer_rsp_t;

  // Each entry holds {sin, cos} of one threshold, both unsigned Q63.
  typedef logic [NTHR-1:0][127:0] trig_tab_t;

  function automatic logic [63:0] mul_q63(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[126:63];
  endfunction

  // Evaluated once at elaboration: Taylor series of sin and cos at each
  // half-degree threshold, with the same truncation at every term.
  function automatic trig_tab_t build_trig_tab();
    trig_tab_t   tab;
    logic [63:0] step;
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] ts;
    logic [63:0] s;
    logic [63:0] tc;
    logic [63:0] c;
    step = PI4_Q64 / 64'd90;
    for (int k = 0; k < NTHR; k++) begin
      th  = (64'(2 * k + 1) * step) >> 1;
      th2 = mul_q63(th, th);
      ts  = th;
      s   = th;
      tc  = Q63_ONE;
      c   = Q63_ONE;
      for (int n = 1; n <= 12; n++) begin
        ts = mul_q63(ts, th2) / 64'((2 * n) * (2 * n + 1));
        tc = mul_q63(tc, th2) / 64'((2 * n - 1) * (2 * n));
        if ((n % 2) == 1) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      tab[k] = {s, c};
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig_tab();

endpackage

[rtl/gtg_atan.sv]
// ----------------------------------------------------------------------------
// gtg_atan
// Octant arctangent by binary search over the half-degree thresholds, using
// one shared 32-bit-slice multiplier and a signed accumulator.
// ----------------------------------------------------------------------------
module gtg_atan import gtg_pkg::*; #(
  parameter int MAG_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] m_i,
  input  logic [MAG_W-1:0] big_i,
  output logic             done_o,
  output logic [OCT_W-1:0] oct_o
);

  localparam int PROD_W = MAG_W + 32;
  localparam int ACC_W  = MAG_W + 65;

  localparam logic [2:0] PH_LAST_MUL = 3'd3;
  localparam logic [2:0] PH_DECIDE   = 3'd5;

  logic             busy_q;
  logic [2:0]       phase_q;
  logic [OCT_W-1:0] lo_q, hi_q, lo_n, hi_n;
  logic             done_q;
  logic [MAG_W-1:0] m_q, big_q;
  logic [PROD_W-1:0] prod_q;
  logic             prod_sh_q, prod_sub_q;
  logic [ACC_W-1:0] acc_q;

  logic [OCT_W:0]   mid_sum;
  logic [OCT_W-1:0] mid;
  logic [127:0]     entry;
  logic [MAG_W-1:0] mul_a;
  logic [31:0]      mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [ACC_W-1:0] addend;
  logic             above;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[OCT_W:1];
  assign entry   = TRIG_TAB[mid];

  // Phases 0..3 form m*cos - big*sin from four 32-bit slices.
  always_comb begin
    case (phase_q[1:0])
      2'd0:    begin mul_a = m_q;   mul_b = entry[31:0];   end
      2'd1:    begin mul_a = m_q;   mul_b = entry[63:32];  end
      2'd2:    begin mul_a = big_q; mul_b = entry[95:64];  end
      default: begin mul_a = big_q; mul_b = entry[127:96]; end
    endcase
  end

  assign mul_p  = {32'd0, mul_a} * {{MAG_W{1'b0}}, mul_b};
  assign addend = prod_sh_q ? {1'b0, prod_q, 32'd0} : {33'd0, prod_q};
  // A tie counts as below the threshold.
  assign above  = !acc_q[ACC_W-1] && (|acc_q);

  always_comb begin
    lo_n = lo_q;
    hi_n = hi_q;
    if (above) begin
      lo_n = mid + OCT_W'(1);
    end else begin
      hi_n = mid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= '0;
        lo_q    <= '0;
        hi_q    <= OCT_W'(NTHR);
      end else if (busy_q) begin
        if (phase_q == PH_DECIDE) begin
          lo_q    <= lo_n;
          hi_q    <= hi_n;
          phase_q <= '0;
          if (lo_n == hi_n) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end else begin
          phase_q <= phase_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q   <= m_i;
      big_q <= big_i;
    end
    if (busy_q && phase_q <= PH_LAST_MUL) begin
      prod_q     <= mul_p;
      prod_sh_q  <= phase_q[0];
      prod_sub_q <= phase_q[1];
    end
    if (busy_q) begin
      if (phase_q == 3'd0) begin
        acc_q <= '0;
      end else if (phase_q != PH_DECIDE) begin
        acc_q <= prod_sub_q ? (acc_q - addend) : (acc_q + addend);
      end
    end
  end

  assign done_o = done_q;
  assign oct_o  = lo_q;

  a_search_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (lo_q < hi_q))
    else $error("gtg_atan: search window collapsed while busy");

  a_done_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (!busy_q && lo_q == hi_q && lo_q <= OCT_W'(NTHR)))
    else $error("gtg_atan: result out of range at completion");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("gtg_atan: start while a search is running");

endmodule

[rtl/gtg_steer.sv]
// ----------------------------------------------------------------------------
// gtg_steer
// Steering law: spin, hold-off and forward drive with wheel PWM trimming.
// Holds the duty and hold-off state of the controller.
// ----------------------------------------------------------------------------
module gtg_steer import gtg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  steer_req_t req_i,
  input  logic       commit_i,
  output steer_rsp_t rsp_o
);

  logic [7:0] left_duty_q, left_duty_d;
  logic [7:0] right_duty_q, right_duty_d;
  logic [7:0] holdoff_q, holdoff_d;

  logic [8:0] err_mag;
  logic [7:0] aerr;
  logic       spin, expired, trim;
  logic [8:0] left_inc, right_inc;
  logic [7:0] left_step, right_step, left_bump, right_bump;
  motor_e     left_motor, right_motor;

  assign err_mag = req_i.err[8] ? 9'(-req_i.err) : 9'(req_i.err);
  assign aerr    = err_mag[7:0];
  assign spin    = aerr > cfg_i.angle_tol;
  assign expired = holdoff_q <= 8'd1;
  assign trim    = aerr >= cfg_i.trim_tol;

  assign left_inc   = {1'b0, left_duty_q} + 9'd1;
  assign right_inc  = {1'b0, right_duty_q} + 9'd1;
  assign left_step  = (left_inc > {1'b0, cfg_i.ceiling}) ? cfg_i.ceiling : left_inc[7:0];
  assign right_step = (right_inc > {1'b0, cfg_i.ceiling}) ? cfg_i.ceiling : right_inc[7:0];
  assign left_bump  = (cfg_i.left_base == PWM_MAX) ? PWM_MAX : cfg_i.left_base + 8'd1;
  assign right_bump = (cfg_i.right_base == PWM_MAX) ? PWM_MAX : cfg_i.right_base + 8'd1;

  always_comb begin
    left_duty_d  = left_duty_q;
    right_duty_d = right_duty_q;
    holdoff_d    = holdoff_q;
    left_motor   = MOTOR_STOP;
    right_motor  = MOTOR_STOP;
    if (req_i.far) begin
      if (spin) begin
        if (req_i.err > 9'sd0) begin
          left_motor  = MOTOR_FWD;
          right_motor = MOTOR_REV;
        end else begin
          left_motor  = MOTOR_REV;
          right_motor = MOTOR_FWD;
        end
        holdoff_d = cfg_i.holdoff;
      end else if (expired) begin
        holdoff_d   = '0;
        left_motor  = MOTOR_FWD;
        right_motor = MOTOR_FWD;
        if (trim) begin
          // The wheel on the outer side of the turn speeds up.
          if (req_i.err > 9'sd0) begin
            right_duty_d = cfg_i.right_base;
            left_duty_d  = (req_i.err >= 9'sd2) ? left_step : left_bump;
          end else if (req_i.err < 9'sd0) begin
            left_duty_d  = cfg_i.left_base;
            right_duty_d = (req_i.err <= -9'sd2) ? right_step : right_bump;
          end else begin
            left_duty_d  = cfg_i.left_base;
            right_duty_d = cfg_i.right_base;
          end
        end
      end else begin
        holdoff_d = holdoff_q - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_duty_q  <= RST_BASE_PWM;
      right_duty_q <= RST_BASE_PWM;
      holdoff_q    <= '0;
    end else if (commit_i) begin
      left_duty_q  <= left_duty_d;
      right_duty_q <= right_duty_d;
      holdoff_q    <= holdoff_d;
    end
  end

  assign rsp_o.left_motor  = left_motor;
  assign rsp_o.right_motor = right_motor;
  assign rsp_o.left_pwm    = left_duty_d;
  assign rsp_o.right_pwm   = right_duty_d;

  a_spin_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && req_i.far && spin) |=> (holdoff_q == $past(cfg_i.holdoff)))
    else $error("gtg_steer: hold-off not reloaded after a spin");

  a_goal_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && !req_i.far) |=> ($stable(left_duty_q) && $stable(right_duty_q)
                                  && $stable(holdoff_q)))
    else $error("gtg_steer: state changed with the goal reached");

  a_motor_pairing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.left_motor == MOTOR_STOP) == (rsp_o.right_motor == MOTOR_STOP))
    else $error("gtg_steer: only one wheel stopped");

endmodule

[rtl/go_to_goal_steering_unit.sv]
// ----------------------------------------------------------------------------
// go_to_goal_steering_unit
// One control tick of a differential-drive go-to-goal controller: bearing to
// the goal, wrapped heading error, and spin / hold-off / drive with trimming.
//
//   Port group   Dir   Handshake                   Contents
//   s_axis_*     in    tvalid/tready               pose and goal of one tick
//   m_axis_*     out   tvalid/tready               motor commands, PWM, angles
//   cfg_*        in    write enable, no wait       one register per write
//
// The binary search for the bearing makes five or six probes through the
// shared multiply-accumulate unit, between the set-up states (difference,
// magnitude, launch) and the finishing states (angle, emit).
// A new request is taken once the previous tick has reached the output
// register, even if that result has not been taken yet. A stalled output
// holds the finished tick and the block waits with it. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
module go_to_goal_steering_unit import gtg_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // current_x, current_y, current_heading, goal_x, goal_y, zero padding
  input  logic [((4*POSITION_BITS+9+7)/8)*8-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // left_motor, right_motor, left_pwm, right_pwm, goal_bearing,
  // heading_error, zero padding
  output logic [OUT_W-1:0]     m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  localparam int PB    = POSITION_BITS;
  localparam int DW    = POSITION_BITS + 1;
  localparam int CMP_W = (DW > 16) ? DW : 16;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DIFF   = 7'b0000010,
    ST_MAG    = 7'b0000100,
    ST_LAUNCH = 7'b0001000,
    ST_ATAN   = 7'b0010000,
    ST_ANGLE  = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  cfg_t   cfg_q;

  logic signed [PB-1:0] cx_q, cy_q, gx_q, gy_q;
  logic signed [8:0]    hd_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [DW-1:0]        ax_q, ay_q;
  logic                 dx_neg_q, dy_neg_q, swap_q, swap_d;
  logic signed [8:0]    bearing_q, err_q;
  logic                 far_q;

  logic                 in_req, out_free, load;
  logic                 atan_start, atan_done;
  logic [OCT_W-1:0]     oct;
  logic [DW-1:0]        atan_m, atan_big;

  logic [6:0]           quad_a;
  logic [7:0]           half_a;
  logic signed [8:0]    bearing_d;
  logic signed [10:0]   err_raw, err_wrap;
  logic                 far_d;

  steer_req_t           steer_req;
  steer_rsp_t           steer_rsp;

  logic                 m_tvalid_q;
  logic [OUT_W-1:0]     m_tdata_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;
  assign load          = (state_q == ST_EMIT) && out_free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.left_base  <= RST_BASE_PWM;
      cfg_q.right_base <= RST_BASE_PWM;
      cfg_q.dist_tol   <= RST_DIST_TOL;
      cfg_q.angle_tol  <= RST_ANGLE_TOL;
      cfg_q.trim_tol   <= RST_TRIM_TOL;
      cfg_q.ceiling    <= RST_CEILING;
      cfg_q.holdoff    <= RST_HOLDOFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT_BASE:  cfg_q.left_base  <= cfg_data_i[7:0];
        CFG_RIGHT_BASE: cfg_q.right_base <= cfg_data_i[7:0];
        CFG_DIST_TOL:   cfg_q.dist_tol   <= cfg_data_i;
        CFG_ANGLE_TOL:  cfg_q.angle_tol  <= cfg_data_i[7:0];
        CFG_TRIM_TOL:   cfg_q.trim_tol   <= cfg_data_i[7:0];
        CFG_CEILING:    cfg_q.ceiling    <= cfg_data_i[7:0];
        CFG_HOLDOFF:    cfg_q.holdoff    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_req) state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_MAG;
      ST_MAG:    state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_ATAN;
      ST_ATAN:   if (atan_done) state_d = ST_ANGLE;
      ST_ANGLE:  state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The octant search always runs with the smaller magnitude on top.
  assign swap_d     = ay_q > ax_q;
  assign atan_start = (state_q == ST_LAUNCH);
  assign atan_m     = swap_d ? ax_q : ay_q;
  assign atan_big   = swap_d ? ay_q : ax_q;

  gtg_atan #(
    .MAG_W (DW)
  ) u_atan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (atan_start),
    .m_i     (atan_m),
    .big_i   (atan_big),
    .done_o  (atan_done),
    .oct_o   (oct)
  );

  // Unfold the octant angle to a full-circle bearing, then wrap the error once.
  assign quad_a    = swap_q ? (DEG_90 - {1'b0, oct}) : {1'b0, oct};
  assign half_a    = dx_neg_q ? (DEG_180 - {1'b0, quad_a}) : {1'b0, quad_a};
  assign bearing_d = dy_neg_q ? -$signed({1'b0, half_a}) : $signed({1'b0, half_a});
  assign err_raw   = 11'(hd_q) - 11'(bearing_d);

  always_comb begin
    if (err_raw > WRAP_HI) begin
      err_wrap = err_raw - WRAP_SPAN;
    end else if (err_raw < WRAP_LO) begin
      err_wrap = err_raw + WRAP_SPAN;
    end else begin
      err_wrap = err_raw;
    end
  end

  assign far_d = (CMP_W'(ax_q) > CMP_W'(cfg_q.dist_tol)) ||
                 (CMP_W'(ay_q) > CMP_W'(cfg_q.dist_tol));

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      cx_q <= s_axis_tdata[PB-1:0];
      cy_q <= s_axis_tdata[2*PB-1:PB];
      hd_q <= s_axis_tdata[2*PB+8:2*PB];
      gx_q <= s_axis_tdata[3*PB+8:2*PB+9];
      gy_q <= s_axis_tdata[4*PB+8:3*PB+9];
    end
    if (state_q == ST_DIFF) begin
      dx_q <= $signed({gx_q[PB-1], gx_q}) - $signed({cx_q[PB-1], cx_q});
      dy_q <= $signed({gy_q[PB-1], gy_q}) - $signed({cy_q[PB-1], cy_q});
    end
    if (state_q == ST_MAG) begin
      ax_q     <= dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
      ay_q     <= dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
      dx_neg_q <= dx_q[DW-1];
      dy_neg_q <= dy_q[DW-1];
    end
    if (state_q == ST_LAUNCH) begin
      swap_q <= swap_d;
    end
    if (state_q == ST_ANGLE) begin
      bearing_q <= bearing_d;
      err_q     <= err_wrap[8:0];
      far_q     <= far_d;
    end
    if (load) begin
      m_tdata_q <= {2'b00, err_q, bearing_q, steer_rsp.right_pwm, steer_rsp.left_pwm,
                    steer_rsp.right_motor, steer_rsp.left_motor};
    end
  end

  assign steer_req.far = far_q;
  assign steer_req.err = err_q;

  gtg_steer u_steer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .req_i    (steer_req),
    .commit_i (load),
    .rsp_o    (steer_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_tvalid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  a_done_in_atan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    atan_done |-> (state_q == ST_ATAN))
    else $error("go_to_goal_steering_unit: bearing search finished out of step");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid)
    else $error("go_to_goal_steering_unit: finished tick not presented");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!atan_done && !load))
    else $error("go_to_goal_steering_unit: activity while idle");

endmodule

[verif/go_to_goal_steering_unit_test.sv]
// ----------------------------------------------------------------------------
// go_to_goal_steering_unit_test
// Self-checking testbench for the go-to-goal steering unit. Pose and goal
// requests are streamed in bursts with random gaps, and the result stream
// stalls on a pattern of its own. Every accepted request is run through a
// local model of the bearing search, heading wrap and drive law, and each
// result is compared field by field against the oldest prediction. The run
// walks through several register settings, the extremes among them, and
// writes registers only once the unit has drained.
// ----------------------------------------------------------------------------
module go_to_goal_steering_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gtg_pkg::*;

  localparam int POS_W = 16;
  localparam int IN_W  = ((4 * POS_W + 9 + 7) / 8) * 8;

  // Half-degree bearing thresholds, 0.5 .. 44.5 degrees.
  localparam int          TRIG_STEPS   = 45;
  localparam logic [63:0] QUARTER_PI   = 64'hC90FDAA22168C235;
  localparam logic [63:0] UNITY_Q63    = 64'h8000000000000000;
  localparam logic [2:0]  CFG_SPARE_IDX = 3'd7;

  typedef struct {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [8:0]  hd;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } pose_goal_t;

  typedef struct {
    logic [1:0]        lm;
    logic [1:0]        rm;
    logic [7:0]        lp;
    logic [7:0]        rp;
    logic signed [8:0] brg;
    logic signed [8:0] err;
  } drive_cmd_t;

  typedef struct {
    logic [7:0]  left_base;
    logic [7:0]  right_base;
    logic [15:0] dist_tol;
    logic [7:0]  angle_tol;
    logic [7:0]  trim_tol;
    logic [7:0]  ceiling;
    logic [7:0]  holdoff;
  } steer_settings_t;

  typedef enum {POSE_ALIGNED, POSE_NEAR, POSE_WILD} pose_kind_e;

  logic            clk_i;
  logic            rst_ni        = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  // current_x, current_y, current_heading, goal_x, goal_y, zero padding
  logic [IN_W-1:0] s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  // left_motor, right_motor, left_pwm, right_pwm, goal_bearing,
  // heading_error, zero padding
  logic [OUT_W-1:0] m_axis_tdata;
  logic            cfg_we_i      = 1'b0;
  logic [2:0]      cfg_idx_i     = '0;
  logic [15:0]     cfg_data_i    = '0;

  go_to_goal_steering_unit #(
    .POSITION_BITS(POS_W)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Model state, mirroring the unit's registers and counters.
  steer_settings_t tune = '{RST_BASE_PWM, RST_BASE_PWM, RST_DIST_TOL, RST_ANGLE_TOL,
                            RST_TRIM_TOL, RST_CEILING, RST_HOLDOFF};
  logic [7:0]  left_duty    = RST_BASE_PWM;
  logic [7:0]  right_duty   = RST_BASE_PWM;
  logic [7:0]  holdoff_left = 8'd0;
  logic [63:0] sin_q63 [TRIG_STEPS];
  logic [63:0] cos_q63 [TRIG_STEPS];

  pose_goal_t pending_poses [$];
  drive_cmd_t expected_cmds [$];
  pose_goal_t pose_in_flight;
  int queued_items   = 0;
  int accepted_items = 0;
  int mismatches     = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int monitor_cycle  = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [63:0] q63_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[126:63];
  endfunction

  // Taylor series to thirteen terms, truncating at every step.
  function automatic void build_trig_tables();
    logic [63:0] step, th, th2, ts, s, tc, c;
    step = QUARTER_PI / 64'd90;
    for (int k = 0; k < TRIG_STEPS; k++) begin
      th  = (64'(2 * k + 1) * step) >> 1;
      th2 = q63_mul(th, th);
      ts  = th;
      s   = th;
      tc  = UNITY_Q63;
      c   = UNITY_Q63;
      for (int n = 1; n <= 12; n++) begin
        ts = q63_mul(ts, th2) / 64'((2 * n) * (2 * n + 1));
        tc = q63_mul(tc, th2) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      sin_q63[k] = s;
      cos_q63[k] = c;
    end
  endfunction

  // Rounded atan(minor / major) in degrees: counts the thresholds passed.
  function automatic int octant_deg(longint unsigned minor, longint unsigned major);
    logic [127:0] lhs, rhs;
    int deg;
    deg = 0;
    for (int k = 0; k < TRIG_STEPS; k++) begin
      lhs = 128'(minor) * 128'(cos_q63[k]);
      rhs = 128'(major) * 128'(sin_q63[k]);
      if (lhs > rhs) deg++;
    end
    return deg;
  endfunction

  function automatic int bearing_deg(longint dx, longint dy);
    longint unsigned ax, ay;
    int a, half;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ay <= ax) a = octant_deg(ay, ax);
    else a = 90 - octant_deg(ax, ay);
    half = (dx < 0) ? 180 - a : a;
    return (dy < 0) ? -half : half;
  endfunction

  function automatic logic [7:0] trim_step(logic [7:0] duty);
    return (int'(duty) + 1 > int'(tune.ceiling)) ? tune.ceiling : duty + 8'd1;
  endfunction

  function automatic logic [7:0] base_plus_one(logic [7:0] base);
    return (base == PWM_MAX) ? PWM_MAX : base + 8'd1;
  endfunction

  // One control tick: updates the duty and hold-off state, returns the command.
  function automatic drive_cmd_t steer_tick(pose_goal_t p);
    longint dx, dy, err;
    longint unsigned ax, ay, aerr;
    int brg;
    drive_cmd_t r;
    dx   = longint'(p.gx) - longint'(p.cx);
    dy   = longint'(p.gy) - longint'(p.cy);
    ax   = (dx < 0) ? -dx : dx;
    ay   = (dy < 0) ? -dy : dy;
    brg  = bearing_deg(dx, dy);
    err  = longint'(p.hd) - brg;
    if (err > 180) err -= 360;
    else if (err < -180) err += 360;
    aerr = (err < 0) ? -err : err;
    r.lm = MOTOR_STOP;
    r.rm = MOTOR_STOP;
    if (ax > tune.dist_tol || ay > tune.dist_tol) begin
      if (aerr > tune.angle_tol) begin
        if (err > 0) begin
          r.lm = MOTOR_FWD;
          r.rm = MOTOR_REV;
        end else begin
          r.lm = MOTOR_REV;
          r.rm = MOTOR_FWD;
        end
        holdoff_left = tune.holdoff;
      end else if (holdoff_left <= 8'd1) begin
        holdoff_left = 8'd0;
        r.lm = MOTOR_FWD;
        r.rm = MOTOR_FWD;
        if (aerr >= tune.trim_tol) begin
          if (err > 0) begin
            right_duty = tune.right_base;
            left_duty  = (err >= 2) ? trim_step(left_duty) : base_plus_one(tune.left_base);
          end else if (err < 0) begin
            left_duty  = tune.left_base;
            right_duty = (err <= -2) ? trim_step(right_duty) : base_plus_one(tune.right_base);
          end else begin
            left_duty  = tune.left_base;
            right_duty = tune.right_base;
          end
        end
      end else begin
        holdoff_left--;
      end
    end
    r.lp  = left_duty;
    r.rp  = right_duty;
    r.brg = 9'(brg);
    r.err = 9'(err);
    return r;
  endfunction

  // --------------------------------------------------------------- checks

  task automatic check_field(string name, logic signed [8:0] want, logic signed [8:0] got);
    if (got !== want) begin
      $display("%0t  %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_cmd(drive_cmd_t want, logic [OUT_W-1:0] d);
    check_field("left_motor", want.lm, d[1:0]);
    check_field("right_motor", want.rm, d[3:2]);
    check_field("left_pwm", want.lp, d[11:4]);
    check_field("right_pwm", want.rp, d[19:12]);
    check_field("goal_bearing", want.brg, d[28:20]);
    check_field("heading_error", want.err, d[37:29]);
  endtask

  // --------------------------------------------------------- driver side

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_cmds.push_back(steer_tick(pose_in_flight));
        accepted_items++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0 || pending_poses.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          pose_in_flight = pending_poses.pop_front();
          s_axis_tdata  <= {7'd0, pose_in_flight.gy, pose_in_flight.gx, pose_in_flight.hd,
                            pose_in_flight.cy, pose_in_flight.cx};
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 4);
              2: gap_left = $urandom_range(5, 20);
              default: gap_left = $urandom_range(21, 60);
            endcase
          end
        end
      end
    end
  end

  // -------------------------------------------------------- monitor side

  // Long stalls in one stretch, short flickers in another, and stretches
  // where the result side is always ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          $display("%0t  result with no request outstanding: %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          check_cmd(expected_cmds.pop_front(), m_axis_tdata);
        end
      end
      monitor_cycle++;
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (monitor_cycle[11] && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 60);
        else if (!monitor_cycle[11] && monitor_cycle[9] && $urandom_range(0, 1) == 0)
          stall_left = $urandom_range(1, 3);
      end
    end
  end

  // ------------------------------------------------------------ stimulus

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      CFG_LEFT_BASE:  tune.left_base  = val[7:0];
      CFG_RIGHT_BASE: tune.right_base = val[7:0];
      CFG_DIST_TOL:   tune.dist_tol   = val;
      CFG_ANGLE_TOL:  tune.angle_tol  = val[7:0];
      CFG_TRIM_TOL:   tune.trim_tol   = val[7:0];
      CFG_CEILING:    tune.ceiling    = val[7:0];
      CFG_HOLDOFF:    tune.holdoff    = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int lb, int rb, int dt, int at, int tt, int ce, int ho);
    write_reg(CFG_LEFT_BASE, 16'(lb));
    write_reg(CFG_RIGHT_BASE, 16'(rb));
    write_reg(CFG_DIST_TOL, 16'(dt));
    write_reg(CFG_ANGLE_TOL, 16'(at));
    write_reg(CFG_TRIM_TOL, 16'(tt));
    write_reg(CFG_CEILING, 16'(ce));
    write_reg(CFG_HOLDOFF, 16'(ho));
  endtask

  task automatic wait_for_drain();
    do @(posedge clk_i);
    while (accepted_items != queued_items || expected_cmds.size() != 0);
  endtask

  task automatic queue_pose(int cx, int cy, int hd, int gx, int gy);
    pose_goal_t p;
    p.cx = 16'(cx);
    p.cy = 16'(cy);
    p.hd = 9'(hd);
    p.gx = 16'(gx);
    p.gy = 16'(gy);
    pending_poses.push_back(p);
    queued_items++;
  endtask

  function automatic int wrap16(int v);
    return int'($signed(16'(v)));
  endfunction

  function automatic int rand_pos();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Aligned poses carry a heading near the true bearing so that the hold-off
  // count can expire and trimming is reached; sgn biases the error's sign.
  task automatic queue_random_pose(pose_kind_e kind, int sgn);
    int cx, cy, gx, gy, dx, dy, hd, off, lim, brg;
    cx = rand_pos();
    cy = rand_pos();
    gx = rand_pos();
    gy = rand_pos();
    hd = int'($urandom_range(0, 511)) - 256;
    case (kind)
      POSE_ALIGNED: begin
        case ($urandom_range(0, 7))
          0, 1: begin
            dx = int'($urandom_range(0, 40)) - 20;
            dy = int'($urandom_range(0, 40)) - 20;
            gx = wrap16(cx + dx);
            gy = wrap16(cy + dy);
          end
          2: if ($urandom_range(0, 1)) gx = cx; else gy = cy;
          3: begin
            dx = int'($urandom_range(0, 60000)) - 30000;
            dy = $urandom_range(0, 1) ? dx : -dx;
            gx = wrap16(cx + dx);
            gy = wrap16(cy + dy);
          end
          default: ;
        endcase
        brg = bearing_deg(gx - cx, gy - cy);
        off = int'($urandom_range(0, tune.angle_tol));
        if ($urandom_range(0, 15) == 0) off = int'(tune.angle_tol) + 1;
        if (sgn < 0 || (sgn == 0 && $urandom_range(0, 1) == 1)) off = -off;
        hd = brg + off;
        if (hd > 180) hd -= 360;
        else if (hd < -180) hd += 360;
        // Same direction, but outside the nominal heading range.
        if ($urandom_range(0, 15) == 0) begin
          if (hd + 360 <= 255) hd += 360;
          else if (hd - 360 >= -256) hd -= 360;
        end
      end
      POSE_NEAR: begin
        lim = ((tune.dist_tol > 16'd1000) ? 1000 : int'(tune.dist_tol)) + 2;
        gx  = wrap16(cx + int'($urandom_range(0, 2 * lim)) - lim);
        gy  = wrap16(cy + int'($urandom_range(0, 2 * lim)) - lim);
      end
      default: ;
    endcase
    queue_pose(cx, cy, hd, gx, gy);
  endtask

  task automatic queue_random_phase(int count);
    int made, len, sgn;
    made = 0;
    while (made < count) begin
      sgn = int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 9) < 7) begin
        len = $urandom_range(1, int'(tune.holdoff) + 12);
        repeat (len) queue_random_pose(POSE_ALIGNED, sgn);
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) queue_random_pose($urandom_range(0, 1) ? POSE_NEAR : POSE_WILD, sgn);
      end
      made += len;
    end
  endtask

  initial begin
    build_trig_tables();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed ticks under the reset settings.
    queue_pose(0, 0, 0, 0, 0);
    queue_pose(-32768, 32767, -45, 32767, -32768);
    queue_pose(0, 0, 1, 100, 0);
    repeat (8) queue_pose(0, 0, 4, 100, 0);
    queue_pose(0, 0, -1, 100, 0);
    queue_pose(0, 0, -7, 100, 0);
    queue_pose(0, 0, 0, 100, 0);
    queue_pose(0, 0, 180, -100, 0);
    queue_pose(0, 0, 90, 0, 100);
    queue_pose(0, 0, -90, 0, -100);
    queue_pose(0, 0, 255, 100, 0);
    queue_pose(0, 0, -256, 100, 0);
    queue_pose(10, 10, 0, 15, 5);
    queue_pose(0, 0, 45, 1000, 1000);
    queue_pose(0, 0, 18, 3, 1);
    queue_pose(0, 0, 27, 2, 1);
    queue_pose(0, 0, 63, 1, 2);
    queue_pose(0, 0, -157, -7, -3);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        // Registers only change once every request has produced its result.
        wait_for_drain();
        repeat (8) @(posedge clk_i);
        case (ph)
          1: begin
            apply_settings(0, 0, 0, 0, 0, 0, 0);
            write_reg(CFG_SPARE_IDX, 16'hFFFF);
          end
          2: apply_settings(255, 255, 0, 180, 0, 255, 255);
          3: apply_settings($urandom_range(0, 255), $urandom_range(0, 255), 65535, 0, 180,
                            $urandom_range(0, 255), 1);
          4: apply_settings(20, 40, 12, 180, 180, 0, 2);
          default: apply_settings($urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(0, 300),
                                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 180)
                                                              : $urandom_range(0, 25),
                                  $urandom_range(0, 4), $urandom_range(0, 255),
                                  $urandom_range(0, 60));
        endcase
      end
      queue_random_phase((ph == 3) ? 60 : 280);
    end

    wait_for_drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/gtg_pkg.sv
rtl/gtg_atan.sv
rtl/gtg_steer.sv
rtl/go_to_goal_steering_unit.sv
verif/go_to_goal_steering_unit_test.sv
